// ===== rtl/efc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efc_pkg
// Shared types and codes for the expiring entry cache.
// ----------------------------------------------------------------------------
package efc_pkg;

  localparam int COUNT_W = 5;
  localparam int CFG_W   = 5;
  localparam int OP_W    = 2;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;

  typedef struct packed {
    logic load;
    logic take_next;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PRUNE = 4'b0010,
    S_DROP  = 4'b0100,
    S_WORK  = 4'b1000
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/expiring_fifo_entry_cache_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// expiring_fifo_entry_cache_core
// Ordered cache of handles with expiry times, kept in a row of slot cells.
// ----------------------------------------------------------------------------
// Use:
//   in_*  : one request word; tuser carries the operation (push, pop, count).
//   out_* : one result word per request; tuser carries accepted and found.
//   cfg_* : write of max_entries, only while the block is idle.
// Each request first prunes expired slots: every cycle the lowest dead slot
// is removed and all slots above it move down one cell. A push over capacity
// then drops oldest slots until it fits, before the new entry is written at the
// top of the occupied row. A pop takes slot zero and shifts the row down.
// A request steps through the prune, drop and work states in that order, and
// its result is registered in the output register from the work state.
// One request is in flight at a time; the next is taken as soon as the result
// sits in the output register.
// Reset clears the occupancy and sets max_entries to 16; slot contents are
// not cleared. While the receiver stalls the result is held and a request
// already taken waits in its last step until the output register frees.
// ----------------------------------------------------------------------------
module expiring_fifo_entry_cache_core #(
  parameter int DEPTH       = 16,
  parameter int HANDLE_BITS = 16,
  parameter int TIME_BITS   = 32,
  localparam int IN_W  = ((3 * TIME_BITS + HANDLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((HANDLE_BITS + efc_pkg::COUNT_W + 7) / 8) * 8
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_tvalid,
  output logic                        in_tready,
  // current_time, created_time, lifetime, entry_handle
  input  wire [IN_W-1:0]              in_tdata,
  // operation
  input  wire [efc_pkg::OP_W-1:0]     in_tuser,
  output logic                        out_tvalid,
  input  wire                         out_tready,
  // handle_out, entry_count
  output logic [OUT_W-1:0]            out_tdata,
  // accepted, found
  output logic [1:0]                  out_tuser,
  input  wire                         cfg_we,
  input  wire [efc_pkg::CFG_W-1:0]    cfg_wdata
);
  import efc_pkg::*;

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;

  state_t                 st_r, st_nxt;
  logic [CW-1:0]          occ_r, occ_nxt;
  logic [CFG_W-1:0]       max_entries_r;
  logic [OP_W-1:0]        op_r;
  logic [TIME_BITS-1:0]   now_r, exp_r;
  logic [HANDLE_BITS-1:0] hnd_r;

  logic                   out_tvalid_r, out_acc_r, out_fnd_r;
  logic [HANDLE_BITS-1:0] out_h_r;
  logic [COUNT_W-1:0]     out_cnt_r;

  logic [TIME_BITS-1:0]   in_now, in_created, in_life, in_exp;
  logic [TIME_BITS:0]     exp_sum;
  logic [HANDLE_BITS-1:0] in_hnd;

  logic [HANDLE_BITS-1:0] cell_h [DEPTH+1];
  logic [TIME_BITS-1:0]   cell_e [DEPTH+1];
  logic [DEPTH-1:0]       cell_dead, hole_pre;
  cell_ctl_t              ctl [DEPTH];

  logic [CMP_W-1:0]       cap;
  logic                   push_ok, occ_ge_cap, any_hole, work_go, in_fire;

  assign in_now     = in_tdata[TIME_BITS-1:0];
  assign in_created = in_tdata[2*TIME_BITS-1:TIME_BITS];
  assign in_life    = in_tdata[3*TIME_BITS-1:2*TIME_BITS];
  assign in_hnd     = in_tdata[3*TIME_BITS+HANDLE_BITS-1:3*TIME_BITS];
  assign exp_sum    = {1'b0, in_created} + {1'b0, in_life};

  always_comb begin
    if (in_created == '0 || in_life == '0) begin
      in_exp = '0;
    end else if (exp_sum[TIME_BITS]) begin
      in_exp = '1;
    end else begin
      in_exp = exp_sum[TIME_BITS-1:0];
    end
  end

  assign in_tready = (st_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign cap = (CMP_W'(max_entries_r) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                         : CMP_W'(max_entries_r);
  assign push_ok    = (op_r == OP_PUSH) && (cap != '0) && (now_r < exp_r);
  assign occ_ge_cap = CMP_W'(occ_r) >= cap;
  assign work_go    = !out_tvalid_r || out_tready;

  assign cell_h[DEPTH] = '0;
  assign cell_e[DEPTH] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    efc_cell #(
      .HANDLE_BITS(HANDLE_BITS),
      .TIME_BITS  (TIME_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl[g]),
      .now        (now_r),
      .next_handle(cell_h[g+1]),
      .next_expiry(cell_e[g+1]),
      .new_handle (hnd_r),
      .new_expiry (exp_r),
      .handle     (cell_h[g]),
      .expiry     (cell_e[g]),
      .dead       (cell_dead[g])
    );
  end

  always_comb begin
    logic run;
    run = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      run = run || (cell_dead[i] && (CW'(i) < occ_r));
      hole_pre[i] = run;
    end
  end
  assign any_hole = hole_pre[DEPTH-1];

  always_comb begin
    st_nxt  = st_r;
    occ_nxt = occ_r;
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i] = '0;
    end
    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          st_nxt = S_PRUNE;
        end
      end
      S_PRUNE: begin
        if (any_hole) begin
          for (int i = 0; i < DEPTH; i++) begin
            ctl[i].take_next = hole_pre[i];
          end
          occ_nxt = occ_r - 1'b1;
        end else begin
          st_nxt = S_DROP;
        end
      end
      S_DROP: begin
        if (push_ok && occ_ge_cap) begin
          for (int i = 0; i < DEPTH; i++) begin
            ctl[i].take_next = 1'b1;
          end
          occ_nxt = occ_r - 1'b1;
        end else begin
          st_nxt = S_WORK;
        end
      end
      S_WORK: begin
        if (work_go) begin
          st_nxt = S_IDLE;
          if (push_ok) begin
            for (int i = 0; i < DEPTH; i++) begin
              ctl[i].load = (occ_r == CW'(i));
            end
            occ_nxt = occ_r + 1'b1;
          end else if (op_r == OP_POP && occ_r != '0) begin
            for (int i = 0; i < DEPTH; i++) begin
              ctl[i].take_next = 1'b1;
            end
            occ_nxt = occ_r - 1'b1;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= S_IDLE;
      occ_r         <= '0;
      max_entries_r <= MAX_ENTRIES_RST;
      out_tvalid_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      occ_r <= occ_nxt;
      if (cfg_we) begin
        max_entries_r <= cfg_wdata;
      end
      if (st_r == S_WORK && work_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_tuser;
      now_r <= in_now;
      exp_r <= in_exp;
      hnd_r <= in_hnd;
    end
    if (st_r == S_WORK && work_go) begin
      out_acc_r <= push_ok;
      out_fnd_r <= !push_ok && (op_r == OP_POP) && (occ_r != '0);
      out_h_r   <= (!push_ok && op_r == OP_POP && occ_r != '0) ? cell_h[0] : '0;
      out_cnt_r <= COUNT_W'(occ_nxt);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = {out_fnd_r, out_acc_r};
  assign out_tdata  = OUT_W'({out_cnt_r, out_h_r});

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(DEPTH) >= occ_r)
    else $error("occupancy beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_WORK && work_go && push_ok) |=> occ_r == $past(occ_r) + 1'b1)
    else $error("accepted push did not grow occupancy");

  a_drop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DROP && push_ok && occ_ge_cap) |=> occ_r == $past(occ_r) - 1'b1)
    else $error("drop did not shrink occupancy");

  a_prune_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_PRUNE && !any_hole) |=> (st_r == S_DROP && $stable(occ_r)))
    else $error("prune finished with changed occupancy");

  a_work_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_WORK && !work_go) |=> st_r == S_WORK)
    else $error("result step left while output busy");

endmodule
`default_nettype wire

// ===== rtl/efc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efc_cell
// One slot of the entry row: holds a handle and expiry, loads a new entry or
// takes its upper neighbour's entry, and flags itself dead against now.
// ----------------------------------------------------------------------------
module efc_cell #(
  parameter int HANDLE_BITS = 16,
  parameter int TIME_BITS   = 32
) (
  input  wire                    clk,
  input  efc_pkg::cell_ctl_t     ctl,
  input  wire [TIME_BITS-1:0]    now,
  input  wire [HANDLE_BITS-1:0]  next_handle,
  input  wire [TIME_BITS-1:0]    next_expiry,
  input  wire [HANDLE_BITS-1:0]  new_handle,
  input  wire [TIME_BITS-1:0]    new_expiry,
  output logic [HANDLE_BITS-1:0] handle,
  output logic [TIME_BITS-1:0]   expiry,
  output logic                   dead
);
  import efc_pkg::*;

  logic [HANDLE_BITS-1:0] handle_r;
  logic [TIME_BITS-1:0]   expiry_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      handle_r <= new_handle;
      expiry_r <= new_expiry;
    end else if (ctl.take_next) begin
      handle_r <= next_handle;
      expiry_r <= next_expiry;
    end
  end

  assign handle = handle_r;
  assign expiry = expiry_r;
  assign dead   = !(now < expiry_r);

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the expiring entry cache. A directed table covers
// the empty store, invalid and expired pushes, saturating expiry, exact expiry,
// pop order and the spare operation code. Random phases follow at several
// capacities, with idling on either side of the streams. Every result word is
// compared field by field with its table row or with a local model of the store.
// ----------------------------------------------------------------------------
module testbench;
  import efc_pkg::*;

  localparam int SLOTS        = 16;
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 205;
  localparam int DRAIN_CYCLES = 4 + 2 * SLOTS + 8;
  localparam int CYCLE_LIMIT  = 1_000_000;

  localparam logic [OP_W-1:0] OP_COUNT = 2'd2;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [31:0]     now;
    logic [31:0]     created;
    logic [31:0]     life;
    logic [15:0]     handle;
  } request_t;

  typedef struct packed {
    logic        accepted;
    logic        found;
    logic [15:0] handle;
    logic [4:0]  count;
  } result_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    result_t  want;
  } row_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic [111:0] in_tdata   = '0;
  logic [1:0]   in_tuser   = '0;
  logic         out_tready = 1'b0;
  logic         cfg_we     = 1'b0;
  logic [4:0]   cfg_wdata  = '0;
  wire          in_tready;
  wire          out_tvalid;
  wire  [23:0]  out_tdata;
  wire  [1:0]   out_tuser;

  expiring_fifo_entry_cache_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // model of the store
  logic [15:0] slot_handle [SLOTS];
  logic [31:0] slot_expiry [SLOTS];
  int unsigned slot_fill    = 0;
  logic [4:0]  capacity     = MAX_ENTRIES_RST;
  logic [31:0] clock_now    = '0;

  result_t     pending_results [$];
  result_t     seen_result;
  result_t     oldest_result;
  int          errors       = 0;
  int          cycle_count  = 0;
  int          send_idle    = 0;
  int          recv_idle    = 0;

  row_t        dir_rows [25];
  logic [4:0]  phase_cap  [PHASES] = '{5'd31, 5'd3, 5'd0, 5'd1, 5'd16, 5'd8};
  int          phase_send [PHASES] = '{23, 23, 63, 63, 0, 0};
  int          phase_recv [PHASES] = '{63, 63, 23, 23, 0, 0};

  function automatic void drop_oldest(int unsigned n);
    if (n >= slot_fill) begin
      slot_fill = 0;
    end else begin
      for (int unsigned i = 0; i + n < slot_fill; i++) begin
        slot_handle[i] = slot_handle[i + n];
        slot_expiry[i] = slot_expiry[i + n];
      end
      slot_fill = slot_fill - n;
    end
  endfunction

  function automatic result_t predict_result(request_t r);
    int unsigned keep;
    int unsigned cap;
    logic [32:0] sum;
    logic [31:0] expiry;
    result_t     res;
    keep = 0;
    res  = '0;
    for (int unsigned i = 0; i < slot_fill; i++) begin
      if (r.now < slot_expiry[i]) begin
        slot_handle[keep] = slot_handle[i];
        slot_expiry[keep] = slot_expiry[i];
        keep++;
      end
    end
    slot_fill = keep;
    cap = (capacity > SLOTS) ? SLOTS : capacity;
    if (r.op == OP_PUSH) begin
      sum    = {1'b0, r.created} + {1'b0, r.life};
      expiry = sum[32] ? '1 : sum[31:0];
      if (r.created == '0 || r.life == '0) expiry = '0;
      if (cap != 0 && r.now < expiry) begin
        if (slot_fill >= cap) drop_oldest(slot_fill - cap + 1);
        slot_handle[slot_fill] = r.handle;
        slot_expiry[slot_fill] = expiry;
        slot_fill++;
        res.accepted = 1'b1;
      end
    end else if (r.op == OP_POP) begin
      if (slot_fill != 0) begin
        res.handle = slot_handle[0];
        res.found  = 1'b1;
        drop_oldest(1);
      end
    end
    res.count = slot_fill[4:0];
    return res;
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    r.handle  = 16'($urandom);
    r.created = $urandom;
    r.life    = $urandom;
    if ($urandom_range(99, 0) < 2) clock_now = $urandom;
    else clock_now = clock_now + $urandom_range(3, 0);
    r.now = clock_now;
    pick = $urandom_range(99, 0);
    if (pick < 55)      r.op = OP_PUSH;
    else if (pick < 80) r.op = OP_POP;
    else if (pick < 95) r.op = OP_COUNT;
    else                r.op = OP_SPARE;
    pick = $urandom_range(99, 0);
    if (pick < 75) begin
      r.created = clock_now - $urandom_range(5, 0);
      r.life    = $urandom_range(80, 1);
    end else if (pick < 82) begin
      r.created = 32'hFFFF_FF00 | $urandom_range(255, 0);
    end else if (pick < 88) begin
      if ($urandom_range(1, 0) == 1) r.created = '0;
      else r.life = '0;
    end
    return r;
  endfunction

  task automatic send_request(request_t r);
    while ($urandom_range(99, 0) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.handle, r.life, r.created, r.now};
    in_tuser  <= r.op;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_result = {out_tuser[0], out_tuser[1], out_tdata[15:0], out_tdata[20:16]};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %h", $time, seen_result);
      end else begin
        oldest_result = pending_results[0];
        pending_results.delete(0);
        check_field("accepted", 32'(oldest_result.accepted), 32'(seen_result.accepted));
        check_field("found", 32'(oldest_result.found), 32'(seen_result.found));
        check_field("handle_out", 32'(oldest_result.handle), 32'(seen_result.handle));
        check_field("entry_count", 32'(oldest_result.count), 32'(seen_result.count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    request_t item;
    result_t  pred;
    dir_rows = '{
      {OP_COUNT, 32'd0, 32'd0, 32'd0, 16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000, 5'd0},
      {OP_POP, 32'd0, 32'd0, 32'd0, 16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000, 5'd0},
      {OP_PUSH, 32'd0, 32'd0, 32'd5, 16'h0001, 1'b1, 1'b0, 1'b0, 16'h0000, 5'd0},
      {OP_PUSH, 32'd0, 32'd5, 32'd0, 16'h0002, 1'b1, 1'b0, 1'b0, 16'h0000, 5'd0},
      {OP_PUSH, 32'd10, 32'd1, 32'd5, 16'h0003, 1'b1, 1'b0, 1'b0, 16'h0000, 5'd0},
      {OP_PUSH, 32'd100, 32'd100, 32'd1, 16'hFFFF, 1'b1, 1'b1, 1'b0, 16'h0000, 5'd1},
      {OP_PUSH, 32'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000,
        1'b1, 1'b1, 1'b0, 16'h0000, 5'd2},
      {OP_PUSH, 32'd100, 32'hFFFF_FFF0, 32'd32, 16'h1234, 1'b1, 1'b1, 1'b0, 16'h0000, 5'd3},
      {OP_COUNT, 32'd100, 32'd0, 32'd0, 16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000, 5'd3},
      {OP_COUNT, 32'd101, 32'd0, 32'd0, 16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000, 5'd2},
      {OP_POP, 32'd101, 32'd0, 32'd0, 16'h0000, 1'b1, 1'b0, 1'b1, 16'h0000, 5'd1},
      {OP_SPARE, 32'd101, 32'd7, 32'd7, 16'h7777, 1'b1, 1'b0, 1'b0, 16'h0000, 5'd1},
      {OP_PUSH, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd1, 16'hAAAA,
        1'b1, 1'b1, 1'b0, 16'h0000, 5'd2},
      {OP_COUNT, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000, 5'd0},
      {OP_PUSH, 32'd200, 32'd190, 32'd100, 16'h5555, 1'b0, 1'b0, 1'b0, 16'h0000, 5'd0},
      {OP_PUSH, 32'd200, 32'd190, 32'd101, 16'h0F0F, 1'b0, 1'b0, 1'b0, 16'h0000, 5'd0},
      {OP_PUSH, 32'd200, 32'd190, 32'd102, 16'hF0F0, 1'b0, 1'b0, 1'b0, 16'h0000, 5'd0},
      {OP_PUSH, 32'd200, 32'd190, 32'd103, 16'h00FF, 1'b0, 1'b0, 1'b0, 16'h0000, 5'd0},
      {OP_PUSH, 32'd200, 32'd190, 32'd104, 16'hFF00, 1'b0, 1'b0, 1'b0, 16'h0000, 5'd0},
      {OP_PUSH, 32'd200, 32'd190, 32'd105, 16'h3C3C, 1'b0, 1'b0, 1'b0, 16'h0000, 5'd0},
      {OP_PUSH, 32'd200, 32'd190, 32'd106, 16'hC3C3, 1'b0, 1'b0, 1'b0, 16'h0000, 5'd0},
      {OP_PUSH, 32'd200, 32'd190, 32'd107, 16'h8001, 1'b0, 1'b0, 1'b0, 16'h0000, 5'd0},
      {OP_PUSH, 32'd200, 32'd200, 32'hFFFF_FFFF, 16'h6666,
        1'b0, 1'b0, 1'b0, 16'h0000, 5'd0},
      {OP_POP, 32'd295, 32'd0, 32'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 5'd0},
      {OP_POP, 32'd0, 32'd0, 32'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 5'd0}
    };
    repeat (8) @(posedge clk);
    rst_n     <= 1'b1;
    send_idle = phase_send[0];
    recv_idle = phase_recv[0];
    foreach (dir_rows[i]) begin
      item = dir_rows[i].req;
      send_request(item);
      pred = predict_result(item);
      pending_results = {pending_results, (dir_rows[i].typed ? dir_rows[i].want : pred)};
    end
    in_tvalid <= 1'b0;
    clock_now = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      // hold the register write until the store is idle
      while (pending_results.size() != 0) @(posedge clk);
      repeat (2) @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= phase_cap[p];
      @(posedge clk);
      cfg_we    <= 1'b0;
      capacity  = phase_cap[p];
      send_idle = phase_send[p];
      recv_idle = phase_recv[p];
      for (int n = 0; n < PHASE_WORDS; n++) begin
        item = random_request();
        send_request(item);
        pred = predict_result(item);
        pending_results = {pending_results, pred};
      end
      in_tvalid <= 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/efc_pkg.sv
rtl/efc_cell.sv
rtl/expiring_fifo_entry_cache_core.sv
dv/testbench.sv
